>>> rtl/ffc_pkg.sv
// Shared widths, register indexes, method codes and sideband type for the friction feedforward.
package ffc_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    // Unsigned magnitudes of the registers and of the clamped target
    localparam int MAG_W = DATA_WIDTH - 1;
    // |target| including the most negative code
    localparam int ABS_W = DATA_WIDTH;
    // u*u
    localparam int SQ_W  = 2 * MAG_W;
    // a1*u, signed
    localparam int LIN_W = DATA_WIDTH + MAG_W + 1;
    // a2*u*u, signed
    localparam int P2_W  = DATA_WIDTH + SQ_W + 1;
    // quadratic sum with 2*FRAC_BITS fraction bits, signed
    localparam int SUM_W = P2_W + 2;
    // floored magnitude with FRAC_BITS fraction bits, unsigned
    localparam int E_W   = SUM_W - 2 * FRAC_BITS;
    // magnitude * |target|
    localparam int N_W   = E_W + ABS_W;
    // quotient bits kept before saturation
    localparam int Q_W   = DATA_WIDTH;

    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] CFG_METHOD       = 3'd0;
    localparam logic [IDX_W-1:0] CFG_FRICTION_POS = 3'd1;
    localparam logic [IDX_W-1:0] CFG_FRICTION_NEG = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ZERO_RANGE   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_COEF_A0      = 3'd4;
    localparam logic [IDX_W-1:0] CFG_COEF_A1      = 3'd5;
    localparam logic [IDX_W-1:0] CFG_COEF_A2      = 3'd6;
    localparam logic [IDX_W-1:0] CFG_TARGET_LIMIT = 3'd7;

    localparam logic [1:0] METH_SYM   = 2'd0;
    localparam logic [1:0] METH_SPLIT = 2'd1;
    localparam logic [1:0] METH_QUAD  = 2'd2;

    // Travels alongside the dividend through the divider
    typedef struct packed {
        logic           neg;   // target is negative
        logic           band;  // inside the linear band: take the quotient
        logic           zero;  // force a zero result
        logic [E_W-1:0] mag;   // magnitude outside the band
    } t_side;

endpackage

>>> rtl/ffc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a saturation flag.
module ffc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ffc_pkg::N_W-1:0]       i_num,
    input  logic [ffc_pkg::MAG_W-1:0]     i_den,
    input  ffc_pkg::t_side                i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ffc_pkg::Q_W-1:0]       o_quot,
    output logic                          o_sat,
    output ffc_pkg::t_side                o_side
);

    localparam int STAGES = ffc_pkg::Q_W + 1;

    logic                        r_v    [STAGES];
    logic [ffc_pkg::N_W-1:0]     r_rem  [STAGES];
    logic [ffc_pkg::Q_W-1:0]     r_quo  [STAGES];
    logic                        r_sat  [STAGES];
    ffc_pkg::t_side              r_side [STAGES];
    logic [STAGES:0]             w_rdy;
    logic [ffc_pkg::N_W-1:0]     w_den_top;

    assign w_rdy[STAGES] = i_ready;
    assign o_ready       = w_rdy[0];
    assign w_den_top     = ffc_pkg::N_W'(i_den) << ffc_pkg::Q_W;

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_rdy
            assign w_rdy[s] = !r_v[s] || w_rdy[s+1];
        end
    endgenerate

    // Entry stage: flag quotients that cannot fit in Q_W bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_rem[0]  <= i_num;
            r_quo[0]  <= '0;
            r_sat[0]  <= (i_num >= w_den_top);
            r_side[0] <= i_side;
        end
    end

    generate
        for (s = 1; s < STAGES; s++) begin : g_stage
            localparam int BIT = ffc_pkg::Q_W - s;
            logic [ffc_pkg::N_W-1:0] w_dsh;
            logic                    w_ge;
            logic [ffc_pkg::N_W-1:0] n_rem;
            logic [ffc_pkg::Q_W-1:0] n_quo;

            assign w_dsh = ffc_pkg::N_W'(i_den) << BIT;
            assign w_ge  = (r_rem[s-1] >= w_dsh);

            always_comb begin
                n_rem      = w_ge ? (r_rem[s-1] - w_dsh) : r_rem[s-1];
                n_quo      = r_quo[s-1];
                n_quo[BIT] = w_ge;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (w_rdy[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[s] && r_v[s-1]) begin
                    r_rem[s]  <= n_rem;
                    r_quo[s]  <= n_quo;
                    r_sat[s]  <= r_sat[s-1];
                    r_side[s] <= r_side[s-1];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[STAGES-1];
    assign o_quot  = r_quo[STAGES-1];
    assign o_sat   = r_sat[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

>>> rtl/friction_feedforward_top.sv
// Friction feedforward: sign, linear band and quadratic fit, pipelined one beat per cycle while not stalled.
// Pipeline: five arithmetic stages, a 17-stage divider for the band slope and one output
//   register lie between an accepted input beat and its output beat.
// Throughput: one beat per cycle while the output takes beats; each stage advances when it
//   is empty or its successor advances, so bubbles close up and input is taken while an output beat waits.
// Reset (synchronous, active low) empties the pipeline and loads register defaults:
//   all zero but target_limit, which resets to full scale.
module friction_feedforward_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [ffc_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [ffc_pkg::DATA_WIDTH-1:0]   i_cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ffc_pkg::DATA_WIDTH-1:0]   s_axis_tdata,   // [15:0] target
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ffc_pkg::DATA_WIDTH-1:0]   m_axis_tdata    // [15:0] feedforward
);

    localparam int DW = ffc_pkg::DATA_WIDTH;
    localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]                       r_method;
    logic [ffc_pkg::MAG_W-1:0]        r_friction_pos;
    logic [ffc_pkg::MAG_W-1:0]        r_friction_neg;
    logic [ffc_pkg::MAG_W-1:0]        r_zero_range;
    logic signed [DW-1:0]             r_coef_a0;
    logic signed [DW-1:0]             r_coef_a1;
    logic signed [DW-1:0]             r_coef_a2;
    logic [ffc_pkg::MAG_W-1:0]        r_target_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method       <= ffc_pkg::METH_SYM;
            r_friction_pos <= '0;
            r_friction_neg <= '0;
            r_zero_range   <= '0;
            r_coef_a0      <= '0;
            r_coef_a1      <= '0;
            r_coef_a2      <= '0;
            r_target_limit <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ffc_pkg::CFG_METHOD:       r_method       <= i_cfg_data[1:0];
                ffc_pkg::CFG_FRICTION_POS: r_friction_pos <= i_cfg_data[ffc_pkg::MAG_W-1:0];
                ffc_pkg::CFG_FRICTION_NEG: r_friction_neg <= i_cfg_data[ffc_pkg::MAG_W-1:0];
                ffc_pkg::CFG_ZERO_RANGE:   r_zero_range   <= i_cfg_data[ffc_pkg::MAG_W-1:0];
                ffc_pkg::CFG_COEF_A0:      r_coef_a0      <= i_cfg_data;
                ffc_pkg::CFG_COEF_A1:      r_coef_a1      <= i_cfg_data;
                ffc_pkg::CFG_COEF_A2:      r_coef_a2      <= i_cfg_data;
                ffc_pkg::CFG_TARGET_LIMIT: r_target_limit <= i_cfg_data[ffc_pkg::MAG_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_o_v;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d, w_rdy_e, w_rdy_o;
    logic w_div_rdy, w_div_v;

    assign w_rdy_o = !r_o_v || m_axis_tready;
    assign w_rdy_e = !r_e_v || w_div_rdy;
    assign w_rdy_d = !r_d_v || w_rdy_e;
    assign w_rdy_c = !r_c_v || w_rdy_d;
    assign w_rdy_b = !r_b_v || w_rdy_c;
    assign w_rdy_a = !r_a_v || w_rdy_b;

    assign s_axis_tready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_rdy_a) r_a_v <= s_axis_tvalid;
            if (w_rdy_b) r_b_v <= r_a_v;
            if (w_rdy_c) r_c_v <= r_b_v;
            if (w_rdy_d) r_d_v <= r_c_v;
            if (w_rdy_e) r_e_v <= r_d_v;
            if (w_rdy_o) r_o_v <= w_div_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: magnitude, clamp, band decision, argument of the quadratic
    // ------------------------------------------------------------------
    logic                        w_neg;
    logic [ffc_pkg::ABS_W-1:0]   w_abs;
    logic [ffc_pkg::MAG_W-1:0]   w_x;
    logic                        w_band01, w_band2, w_quad, w_off;
    logic [ffc_pkg::MAG_W-1:0]   w_u;
    logic [ffc_pkg::MAG_W-1:0]   w_mag01;

    assign w_neg = s_axis_tdata[DW-1];
    // the most negative code gives 2^(DW-1) without wrapping
    assign w_abs = w_neg ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
    assign w_x   = (w_abs > {1'b0, r_target_limit}) ? r_target_limit
                                                    : w_abs[ffc_pkg::MAG_W-1:0];
    assign w_band01 = (r_zero_range != '0) && (w_abs <= {1'b0, r_zero_range});
    assign w_band2  = (r_zero_range != '0) && (w_x < r_zero_range);
    assign w_quad   = (r_method == ffc_pkg::METH_QUAD);
    assign w_off    = (r_method != ffc_pkg::METH_SYM) && (r_method != ffc_pkg::METH_SPLIT)
                   && !w_quad;
    // in the band the quadratic is evaluated at the band edge, never clamped
    assign w_u      = w_band2 ? r_zero_range : w_x;
    assign w_mag01  = (w_neg && (r_method == ffc_pkg::METH_SPLIT)) ? r_friction_neg
                                                                  : r_friction_pos;

    logic                        r_a_neg, r_a_band, r_a_quad, r_a_zero;
    logic [ffc_pkg::ABS_W-1:0]   r_a_abs;
    logic [ffc_pkg::MAG_W-1:0]   r_a_u;
    logic [ffc_pkg::MAG_W-1:0]   r_a_mag01;

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && s_axis_tvalid) begin
            r_a_neg   <= w_neg;
            r_a_abs   <= w_abs;
            r_a_u     <= w_u;
            r_a_band  <= w_quad ? w_band2 : w_band01;
            r_a_quad  <= w_quad;
            r_a_zero  <= w_off || (s_axis_tdata == '0);
            r_a_mag01 <= w_mag01;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: u*u and a1*u
    // ------------------------------------------------------------------
    logic [ffc_pkg::SQ_W-1:0]          w_sq;
    logic signed [ffc_pkg::LIN_W-1:0]  w_a1_ext, w_u_ext, w_lin;

    assign w_sq     = ffc_pkg::SQ_W'(r_a_u) * ffc_pkg::SQ_W'(r_a_u);
    assign w_a1_ext = ffc_pkg::LIN_W'(r_coef_a1);
    assign w_u_ext  = $signed(ffc_pkg::LIN_W'(r_a_u));
    assign w_lin    = w_a1_ext * w_u_ext;

    logic                              r_b_neg, r_b_band, r_b_quad, r_b_zero;
    logic [ffc_pkg::ABS_W-1:0]         r_b_abs;
    logic [ffc_pkg::MAG_W-1:0]         r_b_mag01;
    logic [ffc_pkg::SQ_W-1:0]          r_b_sq;
    logic signed [ffc_pkg::LIN_W-1:0]  r_b_lin;

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_a_v) begin
            r_b_neg   <= r_a_neg;
            r_b_band  <= r_a_band;
            r_b_quad  <= r_a_quad;
            r_b_zero  <= r_a_zero;
            r_b_abs   <= r_a_abs;
            r_b_mag01 <= r_a_mag01;
            r_b_sq    <= w_sq;
            r_b_lin   <= w_lin;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: a2*u*u
    // ------------------------------------------------------------------
    logic signed [ffc_pkg::P2_W-1:0]   w_a2_ext, w_sq_ext, w_p2;

    assign w_a2_ext = ffc_pkg::P2_W'(r_coef_a2);
    assign w_sq_ext = $signed(ffc_pkg::P2_W'(r_b_sq));
    assign w_p2     = w_a2_ext * w_sq_ext;

    logic                              r_c_neg, r_c_band, r_c_quad, r_c_zero;
    logic [ffc_pkg::ABS_W-1:0]         r_c_abs;
    logic [ffc_pkg::MAG_W-1:0]         r_c_mag01;
    logic signed [ffc_pkg::LIN_W-1:0]  r_c_lin;
    logic signed [ffc_pkg::P2_W-1:0]   r_c_p2;

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && r_b_v) begin
            r_c_neg   <= r_b_neg;
            r_c_band  <= r_b_band;
            r_c_quad  <= r_b_quad;
            r_c_zero  <= r_b_zero;
            r_c_abs   <= r_b_abs;
            r_c_mag01 <= r_b_mag01;
            r_c_lin   <= r_b_lin;
            r_c_p2    <= w_p2;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: sum the fit, floor at zero, pick the magnitude for the method
    // ------------------------------------------------------------------
    logic signed [ffc_pkg::SUM_W-1:0]  w_s0, w_s1, w_s2, w_sum;
    logic [ffc_pkg::E_W-1:0]           w_fit, w_mag;

    assign w_s0  = ffc_pkg::SUM_W'(r_coef_a0) <<< (2 * ffc_pkg::FRAC_BITS);
    assign w_s1  = ffc_pkg::SUM_W'(r_c_lin) <<< ffc_pkg::FRAC_BITS;
    assign w_s2  = ffc_pkg::SUM_W'(r_c_p2);
    assign w_sum = w_s0 + w_s1 + w_s2;
    assign w_fit = w_sum[ffc_pkg::SUM_W-1] ? '0
                 : w_sum[ffc_pkg::SUM_W-1:2*ffc_pkg::FRAC_BITS];
    assign w_mag = r_c_quad ? w_fit : ffc_pkg::E_W'(r_c_mag01);

    logic                              r_d_neg, r_d_band, r_d_zero;
    logic [ffc_pkg::ABS_W-1:0]         r_d_abs;
    logic [ffc_pkg::E_W-1:0]           r_d_mag;

    always_ff @(posedge i_clk) begin
        if (w_rdy_d && r_c_v) begin
            r_d_neg  <= r_c_neg;
            r_d_band <= r_c_band;
            r_d_zero <= r_c_zero;
            r_d_abs  <= r_c_abs;
            r_d_mag  <= w_mag;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: dividend of the band slope, magnitude * |target|
    // ------------------------------------------------------------------
    logic [ffc_pkg::N_W-1:0]  w_num;

    assign w_num = ffc_pkg::N_W'(r_d_mag) * ffc_pkg::N_W'(r_d_abs);

    logic [ffc_pkg::N_W-1:0]  r_e_num;
    ffc_pkg::t_side           r_e_side;

    always_ff @(posedge i_clk) begin
        if (w_rdy_e && r_d_v) begin
            r_e_num       <= w_num;
            r_e_side.neg  <= r_d_neg;
            r_e_side.band <= r_d_band;
            r_e_side.zero <= r_d_zero;
            r_e_side.mag  <= r_d_mag;
        end
    end

    // ------------------------------------------------------------------
    // Divide by the band half width; truncation toward zero falls out of
    // dividing magnitudes and restoring the sign afterwards
    // ------------------------------------------------------------------
    logic [ffc_pkg::Q_W-1:0]  w_quot;
    logic                     w_sat;
    ffc_pkg::t_side           w_side;

    ffc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_v),
        .o_ready (w_div_rdy),
        .i_num   (r_e_num),
        .i_den   (r_zero_range),
        .i_side  (r_e_side),
        .o_valid (w_div_v),
        .i_ready (w_rdy_o),
        .o_quot  (w_quot),
        .o_sat   (w_sat),
        .o_side  (w_side)
    );

    // ------------------------------------------------------------------
    // Output register: force zero where flagged, else apply the sign and saturate to DW bits
    // ------------------------------------------------------------------
    logic [ffc_pkg::E_W-1:0]  w_fin;
    logic [ffc_pkg::E_W-1:0]  w_fin_neg;
    logic [DW-1:0]            n_out_data;
    logic [DW-1:0]            r_out_data;

    assign w_fin     = !w_side.band ? w_side.mag
                     : (w_sat ? (ffc_pkg::E_W'(1) << ffc_pkg::Q_W) : ffc_pkg::E_W'(w_quot));
    assign w_fin_neg = ffc_pkg::E_W'(0) - w_fin;

    always_comb begin
        if (w_side.zero) begin
            n_out_data = '0;
        end else if (w_side.neg) begin
            n_out_data = (w_fin > ffc_pkg::E_W'(NEG_MIN)) ? NEG_MIN : w_fin_neg[DW-1:0];
        end else begin
            n_out_data = (w_fin > ffc_pkg::E_W'(POS_MAX)) ? POS_MAX : w_fin[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_o && w_div_v) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> tb/sv/tb_friction_feedforward_top.sv
// Self-checking testbench for the friction feedforward block: directed table, then random phases.
`timescale 1ns / 100ps

module tb_friction_feedforward_top;

    localparam int          CLK_PERIOD       = 10;
    localparam int          RESET_CYCLES     = 5;
    // Input beat to output beat through the block's pipeline registers
    localparam int          LATENCY          = 23;
    localparam int          RAND_PHASES      = 20;
    localparam int          ITEMS_PER_PHASE  = 80;
    // Phase in which the sink holds off long enough to back the pipeline up to the input
    localparam int          HOLD_PHASE       = 3;
    localparam int          LONG_HOLD_CYCLES = 120;
    localparam int          MAX_GAP          = 8;
    // Watchdog limit for the whole run, in nanoseconds
    localparam longint      TIMEOUT_NS       = 5_000_000;
    // Method code with no meaning: the block must answer zero
    localparam logic [1:0]  METH_NONE        = 2'd3;

    typedef enum logic {ROW_CFG, ROW_BEAT} t_row_kind;

    // One row of the directed table: a register write, or a target beat with an
    // optional hand-worked expected feedforward
    typedef struct packed {
        t_row_kind                      kind;
        logic [ffc_pkg::IDX_W-1:0]      idx;
        logic [ffc_pkg::DATA_WIDTH-1:0] value;
        logic                           typed;
        logic [ffc_pkg::DATA_WIDTH-1:0] want;
    } t_stim_row;

    // Target accepted by the block and the feedforward it must produce
    typedef struct packed {
        logic [ffc_pkg::DATA_WIDTH-1:0] target;
        logic [ffc_pkg::DATA_WIDTH-1:0] feedforward;
    } t_ff_pending;

    localparam int DIRECTED_ROWS = 41;

    // Beat rows carry CFG_METHOD in the index column only as filler
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // straight after reset every magnitude is zero
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h7FFF, 1'b1, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h8000, 1'b1, 16'h0000},
        // symmetric constant, no band: pure sign behaviour
        '{ROW_CFG,  ffc_pkg::CFG_FRICTION_POS, 16'h0064, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h0005, 1'b1, 16'h0064},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h0000, 1'b1, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h8000, 1'b1, 16'hFF9C},
        // linear band of 1.0 around zero, band edge included, truncation toward zero
        '{ROW_CFG,  ffc_pkg::CFG_ZERO_RANGE,   16'h0100, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h0080, 1'b1, 16'h0032},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'hFF80, 1'b1, 16'hFFCE},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h0100, 1'b1, 16'h0064},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h0001, 1'b1, 16'h0000},
        // separate negative magnitude: negated both in the band and beyond it
        '{ROW_CFG,  ffc_pkg::CFG_METHOD,       {14'd0, ffc_pkg::METH_SPLIT}, 1'b0, 16'h0000},
        '{ROW_CFG,  ffc_pkg::CFG_FRICTION_NEG, 16'h00C8, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'hFF80, 1'b1, 16'hFF9C},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h8000, 1'b1, 16'hFF38},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h0080, 1'b1, 16'h0032},
        // full-scale band: most negative target lies just outside it
        '{ROW_CFG,  ffc_pkg::CFG_FRICTION_NEG, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_CFG,  ffc_pkg::CFG_ZERO_RANGE,   16'h7FFF, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h8000, 1'b1, 16'h8001},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h7FFF, 1'b1, 16'h0064},
        // meaningless method code
        '{ROW_CFG,  ffc_pkg::CFG_METHOD,       {14'd0, METH_NONE}, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h04D2, 1'b1, 16'h0000},
        // quadratic, constant term only, no band
        '{ROW_CFG,  ffc_pkg::CFG_METHOD,       {14'd0, ffc_pkg::METH_QUAD}, 1'b0, 16'h0000},
        '{ROW_CFG,  ffc_pkg::CFG_ZERO_RANGE,   16'h0000, 1'b0, 16'h0000},
        '{ROW_CFG,  ffc_pkg::CFG_COEF_A0,      16'h0100, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h03E8, 1'b1, 16'h0100},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h8000, 1'b1, 16'hFF00},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h0000, 1'b1, 16'h0000},
        // negative fit floors at zero
        '{ROW_CFG,  ffc_pkg::CFG_COEF_A0,      16'hFF00, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h03E8, 1'b1, 16'h0000},
        // largest square term saturates both ways
        '{ROW_CFG,  ffc_pkg::CFG_COEF_A0,      16'h0000, 1'b0, 16'h0000},
        '{ROW_CFG,  ffc_pkg::CFG_COEF_A2,      16'h7FFF, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h7FFF, 1'b1, 16'h7FFF},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h8000, 1'b1, 16'h8000},
        // clamp on |target| before the linear term
        '{ROW_CFG,  ffc_pkg::CFG_TARGET_LIMIT, 16'h0100, 1'b0, 16'h0000},
        '{ROW_CFG,  ffc_pkg::CFG_COEF_A1,      16'h0100, 1'b0, 16'h0000},
        '{ROW_CFG,  ffc_pkg::CFG_COEF_A2,      16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h7FFF, 1'b1, 16'h0100},
        // band wider than the clamp: slope taken from the fit at the band edge
        '{ROW_CFG,  ffc_pkg::CFG_ZERO_RANGE,   16'h0200, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'h012C, 1'b0, 16'h0000},
        '{ROW_BEAT, ffc_pkg::CFG_METHOD,       16'hFED4, 1'b0, 16'h0000}
    };

    // DUT-facing signals; the ones the bench drives are known from time zero
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [ffc_pkg::IDX_W-1:0]      i_cfg_idx     = ffc_pkg::CFG_METHOD;
    logic [ffc_pkg::DATA_WIDTH-1:0] i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [ffc_pkg::DATA_WIDTH-1:0] s_axis_tdata  = '0;   // [15:0] target
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ffc_pkg::DATA_WIDTH-1:0] m_axis_tdata;         // [15:0] feedforward

    // Shadow of the block's registers, at their reset values
    logic [1:0]                     cfg_method       = ffc_pkg::METH_SYM;
    logic [ffc_pkg::MAG_W-1:0]      cfg_friction_pos = '0;
    logic [ffc_pkg::MAG_W-1:0]      cfg_friction_neg = '0;
    logic [ffc_pkg::MAG_W-1:0]      cfg_zero_range   = '0;
    logic signed [ffc_pkg::DATA_WIDTH-1:0] cfg_coef_a0 = '0;
    logic signed [ffc_pkg::DATA_WIDTH-1:0] cfg_coef_a1 = '0;
    logic signed [ffc_pkg::DATA_WIDTH-1:0] cfg_coef_a2 = '0;
    logic [ffc_pkg::MAG_W-1:0]      cfg_target_limit = '1;

    t_ff_pending            pending_ff [$];
    int unsigned            mismatch_count = 0;
    // Idling controls: burst flags drop the random gaps, the hold request stalls the sink
    bit                     tx_burst       = 1'b0;
    bit                     rx_burst       = 1'b0;
    bit                     rx_long_hold   = 1'b0;

    friction_feedforward_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Quadratic fit at a non-negative x, exact with 2*FRAC_BITS fraction bits,
    // floored at zero and cut back to FRAC_BITS
    function automatic longint quad_floor(input longint x);
        longint sum;
        sum = longint'(cfg_coef_a0) * (longint'(1) << (2 * ffc_pkg::FRAC_BITS))
            + longint'(cfg_coef_a1) * x * (longint'(1) << ffc_pkg::FRAC_BITS)
            + longint'(cfg_coef_a2) * x * x;
        if (sum < 0)
            return 0;
        return sum >>> (2 * ffc_pkg::FRAC_BITS);
    endfunction

    // Feedforward for one target under the shadow registers
    function automatic logic [ffc_pkg::DATA_WIDTH-1:0] predict_feedforward(
        input logic [ffc_pkg::DATA_WIDTH-1:0] raw
    );
        longint t, a, range, x, m, y, hi, lo;
        t     = longint'($signed(raw));
        a     = (t < 0) ? -t : t;          // most negative code gives its true magnitude
        range = longint'(cfg_zero_range);
        y     = 0;
        case (cfg_method)
            ffc_pkg::METH_SYM, ffc_pkg::METH_SPLIT: begin
                m = (t < 0 && cfg_method == ffc_pkg::METH_SPLIT) ? longint'(cfg_friction_neg)
                                                                 : longint'(cfg_friction_pos);
                if (range > 0 && a <= range)
                    y = m * t / range;     // truncates toward zero
                else if (t > 0)
                    y = m;
                else if (t < 0)
                    y = -m;
            end
            ffc_pkg::METH_QUAD: begin
                x = a;
                if (x > longint'(cfg_target_limit))
                    x = longint'(cfg_target_limit);
                // band slope comes from the unclamped fit at the band edge
                if (range > 0 && x < range) begin
                    y = quad_floor(range) * t / range;
                end else begin
                    m = quad_floor(x);
                    if (t > 0)
                        y = m;
                    else if (t < 0)
                        y = -m;
                end
            end
            default: y = 0;
        endcase
        hi = (longint'(1) <<< (ffc_pkg::DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (y > hi)
            y = hi;
        else if (y < lo)
            y = lo;
        return y[ffc_pkg::DATA_WIDTH-1:0];
    endfunction

    // Write one register and mirror it; call at a falling edge with the pipeline empty
    task automatic write_reg(input logic [ffc_pkg::IDX_W-1:0] idx,
                             input logic [ffc_pkg::DATA_WIDTH-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            ffc_pkg::CFG_METHOD:       cfg_method       = data[1:0];
            ffc_pkg::CFG_FRICTION_POS: cfg_friction_pos = data[ffc_pkg::MAG_W-1:0];
            ffc_pkg::CFG_FRICTION_NEG: cfg_friction_neg = data[ffc_pkg::MAG_W-1:0];
            ffc_pkg::CFG_ZERO_RANGE:   cfg_zero_range   = data[ffc_pkg::MAG_W-1:0];
            ffc_pkg::CFG_COEF_A0:      cfg_coef_a0      = data;
            ffc_pkg::CFG_COEF_A1:      cfg_coef_a1      = data;
            ffc_pkg::CFG_COEF_A2:      cfg_coef_a2      = data;
            ffc_pkg::CFG_TARGET_LIMIT: cfg_target_limit = data[ffc_pkg::MAG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one target beat, wait for the handshake and record its expected feedforward;
    // entered and left at a falling edge
    task automatic send_target(
        input logic [ffc_pkg::DATA_WIDTH-1:0] target,
        input logic                           typed,
        input logic [ffc_pkg::DATA_WIDTH-1:0] want
    );
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= target;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        pending_ff.push_back('{target: target,
                               feedforward: typed ? want : predict_feedforward(target)});
        @(negedge i_clk);
    endtask

    // Stop offering, wait for every outstanding feedforward, then let the pipeline settle;
    // entered and left at a falling edge
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_ff.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Unsigned 15-bit magnitude; the spare top bit is random and must be dropped by the block
    function automatic logic [ffc_pkg::DATA_WIDTH-1:0] pick_mag();
        logic [ffc_pkg::MAG_W-1:0] m;
        case ($urandom_range(0, 5))
            0:       m = '0;
            1:       m = '1;
            2, 3:    m = ffc_pkg::MAG_W'($urandom_range(0, 1024));
            default: m = ffc_pkg::MAG_W'($urandom());
        endcase
        return {1'($urandom_range(0, 1)), m};
    endfunction

    // Signed coefficient: extremes, small values that keep the fit in range, or anything
    function automatic logic [ffc_pkg::DATA_WIDTH-1:0] pick_coef();
        logic [ffc_pkg::DATA_WIDTH-1:0] c;
        case ($urandom_range(0, 6))
            0:       c = 16'h8000;
            1:       c = 16'h7FFF;
            2:       c = 16'($urandom_range(0, 2048)) - 16'd1024;
            3:       c = 16'($urandom_range(0, 16)) - 16'd8;
            default: c = 16'($urandom());
        endcase
        return c;
    endfunction

    // Target biased towards the band edge and the clamp, with extremes and full-range noise
    function automatic logic [ffc_pkg::DATA_WIDTH-1:0] pick_target();
        int unsigned                    base, span, m;
        logic [ffc_pkg::DATA_WIDTH-1:0] t;
        base = ($urandom_range(0, 1) != 0) ? int'(cfg_zero_range) : int'(cfg_target_limit);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       t = 16'h7FFF;
                    1:       t = 16'h8000;
                    2:       t = 16'h0000;
                    3:       t = 16'h0001;
                    default: t = 16'hFFFF;
                endcase
            end
            1, 2: begin
                // just either side of the chosen boundary
                m = base + $urandom_range(0, 2);
                if (m > 0)
                    m = m - 1;
                if (m > 32768)
                    m = 32768;
                t = 16'(m);
                if ($urandom_range(0, 1) != 0)
                    t = -t;
            end
            3, 4: begin
                span = base + 2;
                if (span > 32768)
                    span = 32768;
                m = $urandom_range(0, span);
                t = 16'(m);
                if ($urandom_range(0, 1) != 0)
                    t = -t;
            end
            default: t = 16'($urandom());
        endcase
        return t;
    endfunction

    // Fresh setting for a phase: every register written, extremes drawn often
    task automatic randomise_config();
        int unsigned pick;
        logic [1:0]  meth;
        pick = $urandom_range(0, 15);
        if (pick < 5)
            meth = ffc_pkg::METH_SYM;
        else if (pick < 10)
            meth = ffc_pkg::METH_SPLIT;
        else if (pick < 15)
            meth = ffc_pkg::METH_QUAD;
        else
            meth = METH_NONE;
        // upper bits of the method word are junk the block must ignore
        write_reg(ffc_pkg::CFG_METHOD, {14'($urandom()), meth});
        write_reg(ffc_pkg::CFG_FRICTION_POS, pick_mag());
        write_reg(ffc_pkg::CFG_FRICTION_NEG, pick_mag());
        write_reg(ffc_pkg::CFG_ZERO_RANGE, ($urandom_range(0, 3) == 0) ? 16'h0000 : pick_mag());
        write_reg(ffc_pkg::CFG_COEF_A0, pick_coef());
        write_reg(ffc_pkg::CFG_COEF_A1, pick_coef());
        write_reg(ffc_pkg::CFG_COEF_A2, pick_coef());
        write_reg(ffc_pkg::CFG_TARGET_LIMIT, pick_mag());
    endtask

    // Sink: random hold-off before each beat, burst stretches, and one long stall on request
    initial begin : ff_sink
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            if (rx_long_hold) begin
                gap          = LONG_HOLD_CYCLES;
                rx_long_hold = 1'b0;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Check each output beat against the oldest expected feedforward
    always @(posedge i_clk) begin : ff_check
        t_ff_pending head;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (pending_ff.size() == 0) begin
                $display("%0t: unexpected feedforward beat, expected none, got %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                head = pending_ff.pop_front();
                if (m_axis_tdata !== head.feedforward) begin
                    $display("%0t: feedforward for target %h: expected %h, got %h",
                             $time, head.target, head.feedforward, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, random phases, drain and verdict
    initial begin : ff_source
        int phase;
        int n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table; drain before every register write
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                drain_pipeline();
                write_reg(directed_rows[r].idx, directed_rows[r].value);
            end else begin
                send_target(directed_rows[r].value, directed_rows[r].typed,
                            directed_rows[r].want);
            end
        end

        // Random phases, each under a fresh setting
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            drain_pipeline();
            randomise_config();
            tx_burst = ($urandom_range(0, 3) == 0);
            if (phase == HOLD_PHASE) begin
                // stall the sink while the source keeps pushing back to back
                rx_long_hold = 1'b1;
                tx_burst     = 1'b1;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // now and then hold the source until every result is home
                if ($urandom_range(0, 99) == 0)
                    drain_pipeline();
                send_target(pick_target(), 1'b0, '0);
            end
        end

        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin : ff_watchdog
        #(TIMEOUT_NS);
        $display("%0t: timed out with %0d feedforward beats outstanding",
                 $time, pending_ff.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
